[sv/pva_pkg.sv]
package pva_pkg;

	localparam int unsigned HUE_FULL    = 23040;
	localparam int unsigned HUE_SECTOR  = 3840;
	localparam int unsigned ONE_Q16     = 65536;
	localparam int unsigned MIN_SPAN    = 20;
	localparam int unsigned S_LOW       = 5243;
	localparam int unsigned V_BRIGHT    = 57672;
	localparam int unsigned S_PALE      = 13107;
	localparam int unsigned HUE_5       = 320;
	localparam int unsigned HUE_45      = 2880;
	localparam int unsigned HUE_65      = 4160;
	localparam int unsigned HUE_345     = 22080;
	localparam int unsigned OFF_RED     = 23040;
	localparam int unsigned OFF_GREEN   = 7680;
	localparam int unsigned OFF_BLUE    = 15360;
	localparam int unsigned GAIN_SKIN   = 24;
	localparam int unsigned GAIN_WARM   = 30;
	localparam int unsigned GAIN_FULL   = 60;
	localparam int unsigned DIV_RND     = 5000;
	// ceil(2^44 / 10000), exact floor division for dividends below 2^30
	localparam longint unsigned DIV_MAGIC = 64'd1759218605;
	localparam int unsigned DIV_SHIFT   = 44;
	// 65536 * 3840
	localparam int unsigned W_FULL      = 251658240;

	localparam logic [1:0] CH_RED   = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_BLUE  = 2'd2;

	typedef enum logic [1:0] {
		KIND_V,
		KIND_P,
		KIND_Q,
		KIND_T
	} pva_kind_t;

	function automatic pva_kind_t chan_kind(input logic [2:0] sec, input logic [1:0] ch);
		pva_kind_t kr;
		pva_kind_t kg;
		pva_kind_t kb;
		case (sec)
			3'd0: begin
				kr = KIND_V; kg = KIND_T; kb = KIND_P;
			end
			3'd1: begin
				kr = KIND_Q; kg = KIND_V; kb = KIND_P;
			end
			3'd2: begin
				kr = KIND_P; kg = KIND_V; kb = KIND_T;
			end
			3'd3: begin
				kr = KIND_P; kg = KIND_Q; kb = KIND_V;
			end
			3'd4: begin
				kr = KIND_T; kg = KIND_P; kb = KIND_V;
			end
			default: begin
				kr = KIND_V; kg = KIND_P; kb = KIND_Q;
			end
		endcase
		case (ch)
			CH_RED:   chan_kind = kr;
			CH_GREEN: chan_kind = kg;
			default:  chan_kind = kb;
		endcase
	endfunction

	// weight subtracted from the full scale, times s
	function automatic logic [11:0] kind_weight(input pva_kind_t k, input logic [11:0] frac);
		case (k)
			KIND_V:  kind_weight = 12'd0;
			KIND_P:  kind_weight = 12'(HUE_SECTOR);
			KIND_Q:  kind_weight = frac;
			default: kind_weight = 12'(HUE_SECTOR) - frac;
		endcase
	endfunction

endpackage

[sv/pixel_vibrance_adjust_core.sv]
// pixel vibrance adjust: one rgb888 pixel in, one rgb888 pixel out
// input channel in_valid/in_ready carries in_red, in_green, in_blue per beat
// output channel out_valid/out_ready carries out_red, out_green, out_blue
// and was_adjusted per beat; was_adjusted is 0 when the pixel passed through
// config channel cfg_valid/cfg_ready writes the signed 8-bit vibrance;
// cfg_ready is always high, write it only while the pipe is empty
// each input beat passes through the stage registers s1 to s11 in order,
// and out_valid is the valid bit of stage 11
// throughput: one pixel per cycle while out_ready does not stall the pipe,
// set by an 11-stage pipeline; no stage chains more than one multiply
// the hue and saturation quotients use a reciprocal table, a multiply and
// a one-step remainder correction; the boost divide by 10000 is a
// multiply by a magic constant
// reset clears vibrance to 0 and all stage valid bits
// when the receiver stalls, the whole pipe holds: in_ready follows
// out_ready whenever the output stage is full, nothing is dropped
module pixel_vibrance_adjust_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_red,
	input  logic [7:0] in_green,
	input  logic [7:0] in_blue,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_red,
	output logic [7:0] out_green,
	output logic [7:0] out_blue,
	output logic       was_adjusted,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data
);
	import pva_pkg::*;

	// vibrance register
	logic signed [7:0] vib_q;

	// reciprocal floor(2^24/x) and value q1.16 tables
	logic [19:0] recip_tbl [256];
	logic [16:0] v16_tbl [256];

	for (genvar i = 0; i < 256; i++) begin : g_tbl
		localparam int unsigned RV = (i < MIN_SPAN) ? 32'hFFFFF : (1 << 24) / ((i < 1) ? 1 : i);
		localparam int unsigned VV = (i * ONE_Q16 + 127) / 255;
		assign recip_tbl[i] = RV[19:0];
		assign v16_tbl[i]   = VV[16:0];
	end

	logic en;

	// stage valid bits
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic vld_s7, vld_s8, vld_s9, vld_s10, vld_s11;

	// pass-through flags and original pixel, carried down the pipe
	logic skip_s1, skip_s2, skip_s3, skip_s4, skip_s5, skip_s6;
	logic skip_s7, skip_s8, skip_s9, skip_s10;
	logic [7:0] rgb_s1 [3];
	logic [7:0] rgb_s2 [3];
	logic [7:0] rgb_s3 [3];
	logic [7:0] rgb_s4 [3];
	logic [7:0] rgb_s5 [3];
	logic [7:0] rgb_s6 [3];
	logic [7:0] rgb_s7 [3];
	logic [7:0] rgb_s8 [3];
	logic [7:0] rgb_s9 [3];
	logic [7:0] rgb_s10 [3];

	// value in q1.16
	logic [16:0] v16_s1, v16_s2, v16_s3, v16_s4, v16_s5, v16_s6;
	logic [16:0] v16_s7, v16_s8, v16_s9;

	// quotient operands
	logic [7:0]  d_s1, d_s2, d_s3;
	logic [7:0]  mx_s1, mx_s2, mx_s3;
	logic [22:0] t_s1, t_s2, t_s3;
	logic [23:0] n_s1, n_s2, n_s3;
	logic [19:0] rd_s1, rm_s1;
	logic [14:0] qh0_s2, qh0_s3;
	logic [16:0] qs0_s2, qs0_s3;
	logic [22:0] ph_s3;
	logic [24:0] ps_s3;

	// hsv
	logic [14:0] h_s4;
	logic [16:0] s16_s4, s16_s5, s16_s6, s16_s7;
	logic        neg_s5, neg_s6, neg_s7;
	logic [24:0] a_s5;
	logic [5:0]  m6_s5;
	logic [28:0] b_s6;
	logic [16:0] mag_s7;
	logic [16:0] sn_s8;
	logic [11:0] g_s5 [3];
	logic [11:0] g_s6 [3];
	logic [11:0] g_s7 [3];
	logic [11:0] g_s8 [3];
	logic [28:0] p_s9 [3];
	logic [30:0] hi_s10 [3];
	logic [30:0] lo_s10 [3];

	// output stage
	logic [7:0] out_s11 [3];
	logic       adj_s11;

	assign en        = !vld_s11 || out_ready;
	assign in_ready  = en;
	assign cfg_ready = 1'b1;
	assign out_valid = vld_s11;
	assign out_red   = out_s11[0];
	assign out_green = out_s11[1];
	assign out_blue  = out_s11[2];
	assign was_adjusted = adj_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vib_q <= '0;
		end else if (cfg_valid) begin
			vib_q <= cfg_data;
		end
	end

	// stage 1: max, min, span, hue and saturation dividends
	logic [7:0]  mx_c, mn_c, d_c, na_c, nb_c;
	logic [14:0] off_c;
	logic [24:0] t_wide;
	logic        skip_c;

	always_comb begin
		mx_c = in_red;
		mn_c = in_red;
		if (in_green > mx_c) mx_c = in_green;
		if (in_blue > mx_c)  mx_c = in_blue;
		if (in_green < mn_c) mn_c = in_green;
		if (in_blue < mn_c)  mn_c = in_blue;
		d_c = mx_c - mn_c;
		// red wins ties, then green
		if (mx_c == in_red) begin
			off_c = 15'(OFF_RED);   na_c = in_green; nb_c = in_blue;
		end else if (mx_c == in_green) begin
			off_c = 15'(OFF_GREEN); na_c = in_blue;  nb_c = in_red;
		end else begin
			off_c = 15'(OFF_BLUE);  na_c = in_red;   nb_c = in_green;
		end
		// nonnegative, so modular arithmetic is exact
		t_wide = 25'(off_c) * 25'(d_c) + 25'(HUE_SECTOR) * 25'(na_c)
			- 25'(HUE_SECTOR) * 25'(nb_c) + 25'(d_c >> 1);
		skip_c = (vib_q == 8'sd0) || (d_c < 8'(MIN_SPAN));
	end

	// stage 4 helpers: remainder correction
	logic [22:0] remh_c;
	logic [24:0] rems_c;
	logic [14:0] hpre_c;
	logic [14:0] h_c;
	logic [16:0] s_c;

	always_comb begin
		remh_c = t_s3 - ph_s3;
		rems_c = 25'(n_s3) - ps_s3;
		hpre_c = qh0_s3 + 15'(remh_c >= 23'(d_s3));
		h_c    = (hpre_c >= 15'(HUE_FULL)) ? hpre_c - 15'(HUE_FULL) : hpre_c;
		s_c    = qs0_s3 + 17'(rems_c >= 25'(mx_s3));
	end

	// stage 5 helpers: hue gain, boost factor, sector weights
	logic [5:0]  m6_c;
	logic [7:0]  absvib_c;
	logic [2:0]  sec_c;
	logic [11:0] frac_c;

	always_comb begin
		if (h_s4 >= 15'(HUE_5) && h_s4 <= 15'(HUE_45)) begin
			m6_c = 6'(GAIN_SKIN);
		end else if (h_s4 <= 15'(HUE_5) || h_s4 >= 15'(HUE_345)) begin
			m6_c = 6'(GAIN_WARM);
		end else if (h_s4 >= 15'(HUE_45) && h_s4 <= 15'(HUE_65)) begin
			m6_c = 6'(GAIN_WARM);
		end else begin
			m6_c = 6'(GAIN_FULL);
		end
		absvib_c = vib_q[7] ? 8'(-vib_q) : 8'(vib_q);
		sec_c = 3'(h_s4 >= 15'(HUE_SECTOR)) + 3'(h_s4 >= 15'(2 * HUE_SECTOR))
			+ 3'(h_s4 >= 15'(3 * HUE_SECTOR)) + 3'(h_s4 >= 15'(4 * HUE_SECTOR))
			+ 3'(h_s4 >= 15'(5 * HUE_SECTOR));
		frac_c = 12'(h_s4 - 15'(sec_c) * 15'(HUE_SECTOR));
	end

	// stage 6, 7 and 8 helpers
	logic [30:0] b_c;
	logic [60:0] c_c;
	logic [17:0] sum_c;
	logic [16:0] sn_c;

	always_comb begin
		b_c = 31'(a_s5) * 31'(m6_s5);
		c_c = 61'(30'(b_s6) + 30'(DIV_RND)) * 61'(DIV_MAGIC);
		sum_c = 18'(s16_s7) + 18'(mag_s7);
		if (neg_s7) begin
			sn_c = (mag_s7 > s16_s7) ? 17'd0 : s16_s7 - mag_s7;
		end else begin
			sn_c = (sum_c > 18'(ONE_Q16)) ? 17'(ONE_Q16) : sum_c[16:0];
		end
	end

	// stage 10 and 11 helpers
	logic [27:0] w_c [3];
	logic [44:0] acc_c [3];
	logic [49:0] y_c [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			w_c[k]   = 28'(W_FULL) - 28'(p_s9[k]);
			acc_c[k] = (45'(hi_s10[k]) << 14) + 45'(lo_s10[k]);
			y_c[k]   = (50'(acc_c[k]) << 4) + 50'(acc_c[k]) + (50'd1 << 39);
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0; vld_s2  <= 1'b0; vld_s3 <= 1'b0; vld_s4 <= 1'b0;
			vld_s5  <= 1'b0; vld_s6  <= 1'b0; vld_s7 <= 1'b0; vld_s8 <= 1'b0;
			vld_s9  <= 1'b0; vld_s10 <= 1'b0; vld_s11 <= 1'b0;
		end else if (en) begin
			vld_s1  <= in_valid;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (en) begin
			// stage 1
			rgb_s1[0] <= in_red;
			rgb_s1[1] <= in_green;
			rgb_s1[2] <= in_blue;
			skip_s1 <= skip_c;
			d_s1    <= d_c;
			mx_s1   <= mx_c;
			t_s1    <= t_wide[22:0];
			n_s1    <= {d_c, 16'd0} + 24'(mx_c >> 1);
			rd_s1   <= recip_tbl[d_c];
			rm_s1   <= recip_tbl[mx_c];
			v16_s1  <= v16_tbl[mx_c];
			// stage 2: quotient estimates
			qh0_s2 <= 15'((43'(t_s1) * 43'(rd_s1)) >> 24);
			qs0_s2 <= 17'((44'(n_s1) * 44'(rm_s1)) >> 24);
			t_s2 <= t_s1; n_s2 <= n_s1; d_s2 <= d_s1; mx_s2 <= mx_s1;
			v16_s2 <= v16_s1; skip_s2 <= skip_s1; rgb_s2 <= rgb_s1;
			// stage 3: back-multiply for remainder
			ph_s3 <= 23'(qh0_s2) * 23'(d_s2);
			ps_s3 <= 25'(qs0_s2) * 25'(mx_s2);
			qh0_s3 <= qh0_s2; qs0_s3 <= qs0_s2;
			t_s3 <= t_s2; n_s3 <= n_s2; d_s3 <= d_s2; mx_s3 <= mx_s2;
			v16_s3 <= v16_s2; skip_s3 <= skip_s2; rgb_s3 <= rgb_s2;
			// stage 4: exact hue and saturation, late pass-through tests
			h_s4   <= h_c;
			s16_s4 <= s_c;
			skip_s4 <= skip_s3 || (s_c < 17'(S_LOW))
				|| (v16_s3 > 17'(V_BRIGHT) && s_c < 17'(S_PALE));
			v16_s4 <= v16_s3; rgb_s4 <= rgb_s3;
			// stage 5
			a_s5   <= 25'(17'(ONE_Q16) - s16_s4) * 25'(absvib_c);
			m6_s5  <= m6_c;
			neg_s5 <= vib_q[7];
			g_s5[0] <= kind_weight(chan_kind(sec_c, CH_RED), frac_c);
			g_s5[1] <= kind_weight(chan_kind(sec_c, CH_GREEN), frac_c);
			g_s5[2] <= kind_weight(chan_kind(sec_c, CH_BLUE), frac_c);
			s16_s5 <= s16_s4; v16_s5 <= v16_s4; skip_s5 <= skip_s4; rgb_s5 <= rgb_s4;
			// stage 6
			b_s6 <= b_c[28:0];
			neg_s6 <= neg_s5; g_s6 <= g_s5; s16_s6 <= s16_s5;
			v16_s6 <= v16_s5; skip_s6 <= skip_s5; rgb_s6 <= rgb_s5;
			// stage 7: divide by 10000
			mag_s7 <= c_c[60:DIV_SHIFT];
			neg_s7 <= neg_s6; g_s7 <= g_s6; s16_s7 <= s16_s6;
			v16_s7 <= v16_s6; skip_s7 <= skip_s6; rgb_s7 <= rgb_s6;
			// stage 8: new saturation
			sn_s8 <= sn_c;
			g_s8 <= g_s7; v16_s8 <= v16_s7; skip_s8 <= skip_s7; rgb_s8 <= rgb_s7;
			// stage 9
			for (int k = 0; k < 3; k++) begin
				p_s9[k] <= 29'(sn_s8) * 29'(g_s8[k]);
			end
			v16_s9 <= v16_s8; skip_s9 <= skip_s8; rgb_s9 <= rgb_s8;
			// stage 10: v times weight, split in two halves
			for (int k = 0; k < 3; k++) begin
				hi_s10[k] <= 31'(v16_s9) * 31'(w_c[k][27:14]);
				lo_s10[k] <= 31'(v16_s9) * 31'(w_c[k][13:0]);
			end
			skip_s10 <= skip_s9; rgb_s10 <= rgb_s9;
			// stage 11: round to channel
			for (int k = 0; k < 3; k++) begin
				out_s11[k] <= skip_s10 ? rgb_s10[k] : y_c[k][47:40];
			end
			adj_s11 <= !skip_s10;
		end
	end

`ifndef SYNTHESIS
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 && !skip_s3 |-> (25'(n_s3) - ps_s3) < 25'(2 * mx_s3)
			&& (t_s3 - ph_s3) < 23'(2 * d_s3))
		else $error("quotient estimate off by more than one");

	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 && !skip_s4 |-> h_s4 < 15'(HUE_FULL))
		else $error("hue out of range");

	a_sat_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 && !skip_s4 |-> s16_s4 <= 17'(ONE_Q16))
		else $error("saturation above one");

	a_new_sat: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s8 && !skip_s8 |-> sn_s8 <= 17'(ONE_Q16))
		else $error("clamped saturation above one");

	a_adj_vib: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && was_adjusted |-> vib_q != 8'sd0)
		else $error("pixel adjusted with zero vibrance");
`endif

endmodule

[dv/pixel_vibrance_adjust_core_test.sv]
module pixel_vibrance_adjust_core_test;
	timeunit 1ns;
	timeprecision 1ps;
	import pva_pkg::*;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       adjusted;
	} pixel_out_t;

	// rounded channel value from a q1.16 * q1.16 * sector-scaled product
	function automatic longint unsigned to_channel(input longint unsigned num);
		longint unsigned den;
		den = longint'(ONE_Q16) * ONE_Q16 * HUE_SECTOR;
		return (num * 255 + den / 2) / den;
	endfunction

	// vibrance boost of one pixel under a given signed strength
	function automatic pixel_out_t vibrance_predict(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b, input logic signed [7:0] vib);
		pixel_out_t res;
		int unsigned mx, mn, d, v16, s16, h64, sec, frac;
		longint tot, prod, mag, boost, sn;
		longint unsigned full, pv, pp, pq, pt;
		int f10;
		mx = r; mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		d = mx - mn;
		res = '{r, g, b, 1'b0};
		if (vib == 0 || d < MIN_SPAN) return res;
		v16 = (mx * ONE_Q16 + 127) / 255;
		s16 = (d * ONE_Q16 + mx / 2) / mx;
		if (s16 < S_LOW) return res;
		if (v16 > V_BRIGHT && s16 < S_PALE) return res;
		if (mx == r) tot = longint'(OFF_RED) * d + 3840 * (longint'(g) - longint'(b));
		else if (mx == g) tot = longint'(OFF_GREEN) * d + 3840 * (longint'(b) - longint'(r));
		else tot = longint'(OFF_BLUE) * d + 3840 * (longint'(r) - longint'(g));
		h64 = 32'((tot + d / 2) / d);
		if (h64 >= HUE_FULL) h64 -= HUE_FULL;
		if (h64 >= HUE_5 && h64 <= HUE_45) f10 = 4;
		else if (h64 <= HUE_5 || h64 >= HUE_345) f10 = 5;
		else if (h64 >= HUE_45 && h64 <= HUE_65) f10 = 5;
		else f10 = 10;
		prod = longint'(ONE_Q16 - s16) * longint'(vib) * 6 * f10;
		mag = prod < 0 ? -prod : prod;
		mag = (mag + 5000) / 10000;
		boost = prod < 0 ? -mag : mag;
		sn = s16 + boost;
		if (sn < 0) sn = 0;
		if (sn > ONE_Q16) sn = ONE_Q16;
		sec = h64 / HUE_SECTOR;
		frac = h64 % HUE_SECTOR;
		full = longint'(ONE_Q16) * HUE_SECTOR;
		pv = to_channel(v16 * full);
		pp = to_channel(v16 * ((ONE_Q16 - sn) * HUE_SECTOR));
		pq = to_channel(v16 * (full - sn * frac));
		pt = to_channel(v16 * (full - sn * (HUE_SECTOR - frac)));
		case (sec)
			0: res = '{pv[7:0], pt[7:0], pp[7:0], 1'b1};
			1: res = '{pq[7:0], pv[7:0], pp[7:0], 1'b1};
			2: res = '{pp[7:0], pv[7:0], pt[7:0], 1'b1};
			3: res = '{pp[7:0], pq[7:0], pv[7:0], 1'b1};
			4: res = '{pt[7:0], pp[7:0], pv[7:0], 1'b1};
			default: res = '{pv[7:0], pp[7:0], pq[7:0], 1'b1};
		endcase
		return res;
	endfunction

	class pixel_scoreboard;
		pixel_out_t pending[$];
		logic signed [7:0] vibrance;
		int errors;
		int checked;
		int boosted;

		function void note_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
			pending.push_back(vibrance_predict(r, g, b, vibrance));
		endfunction

		function void check_pixel(input pixel_out_t got);
			pixel_out_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected pixel %h", $realtime, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			checked++;
			if (got.adjusted) boosted++;
			if (got.red !== want.red) begin
				$display("%0t: red expected %0d actual %0d", $realtime, want.red, got.red);
				errors++;
			end
			if (got.green !== want.green) begin
				$display("%0t: green expected %0d actual %0d", $realtime, want.green, got.green);
				errors++;
			end
			if (got.blue !== want.blue) begin
				$display("%0t: blue expected %0d actual %0d", $realtime, want.blue, got.blue);
				errors++;
			end
			if (got.adjusted !== want.adjusted) begin
				$display("%0t: was_adjusted expected %0b actual %0b", $realtime,
					want.adjusted, got.adjusted);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic [7:0] in_red = 0, in_green = 0, in_blue = 0;
	logic out_valid;
	logic out_ready = 0;
	logic [7:0] out_red, out_green, out_blue;
	logic was_adjusted;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [7:0] cfg_data = 0;

	pixel_scoreboard board = new();
	int cycle_count = 0;
	// long receiver hold-off, requested by the stimulus and counted down here
	int hold_cycles = 0;
	bit hold_request = 0;
	bit stall_enable = 1;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PIPE_LATENCY = 11;

	always #2 clk = ~clk;

	pixel_vibrance_adjust_core DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.in_red(in_red), .in_green(in_green), .in_blue(in_blue),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_red(out_red), .out_green(out_green), .out_blue(out_blue),
		.was_adjusted(was_adjusted),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// watchdog on the total run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// receiver: random stalls per beat, plus the long hold-off on request
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			if (hold_request) begin
				out_ready <= 0;
				hold_cycles = 300;
				while (hold_cycles > 0) begin
					@(posedge clk);
					hold_cycles--;
				end
				hold_request = 0;
			end
			gap = stall_enable ? $urandom_range(0, 8) : 0;
			if ($urandom_range(0, 3) == 0) gap = 0;
			if (gap > 0) begin
				out_ready <= 0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1;
			// wait for one output beat
			do @(posedge clk); while (!(out_valid && out_ready));
			board.check_pixel('{out_red, out_green, out_blue, was_adjusted});
		end
	end

	// send one pixel beat, random idle before it if idle is set; valid stays up afterwards
	// until the next idle gap or an explicit drop
	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
			input bit idle);
		int gap;
		gap = idle ? $urandom_range(0, 8) : 0;
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		in_red <= r;
		in_green <= g;
		in_blue <= b;
		do @(posedge clk); while (!in_ready);
		board.note_pixel(r, g, b);
	endtask

	// write vibrance while the pipe is drained
	task automatic write_vibrance(input logic signed [7:0] vib);
		in_valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (PIPE_LATENCY + 2) @(posedge clk);
		cfg_valid <= 1;
		cfg_data <= vib;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		board.vibrance = vib;
	endtask

	// saturated-ish pixel with random hue, to get past the pass-through tests
	task automatic send_colorful(input bit idle);
		logic [7:0] hi, lo, mid;
		hi = 8'($urandom_range(40, 255));
		lo = 8'($urandom_range(0, hi - 20));
		mid = 8'($urandom_range(lo, hi));
		case ($urandom_range(0, 5))
			0: send_pixel(hi, mid, lo, idle);
			1: send_pixel(mid, hi, lo, idle);
			2: send_pixel(lo, hi, mid, idle);
			3: send_pixel(lo, mid, hi, idle);
			4: send_pixel(mid, lo, hi, idle);
			default: send_pixel(hi, lo, mid, idle);
		endcase
	endtask

	initial begin
		logic signed [7:0] strengths[8] = '{8'sd100, -8'sd100, 8'sd127, 8'sh80,
			8'sd1, -8'sd1, 8'sd50, -8'sd37};
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// after reset vibrance is 0: everything passes through
		send_pixel(8'd255, 8'd0, 8'd0, 0);
		send_pixel(8'd10, 8'd200, 8'd90, 0);

		write_vibrance(8'sd100);
		// extremes, grey, near-grey, low saturation, bright pale, each hue band
		send_pixel(8'd0, 8'd0, 8'd0, 0);
		send_pixel(8'd255, 8'd255, 8'd255, 0);
		send_pixel(8'd100, 8'd119, 8'd100, 0);
		send_pixel(8'd100, 8'd120, 8'd100, 0);
		send_pixel(8'd255, 8'd240, 8'd235, 0);
		send_pixel(8'd250, 8'd230, 8'd220, 0);
		send_pixel(8'd255, 8'd0, 8'd0, 0);
		send_pixel(8'd0, 8'd255, 8'd0, 0);
		send_pixel(8'd0, 8'd0, 8'd255, 0);
		send_pixel(8'd200, 8'd120, 8'd80, 0);
		send_pixel(8'd200, 8'd190, 8'd60, 0);
		send_pixel(8'd200, 8'd60, 8'd80, 0);
		send_pixel(8'd200, 8'd60, 8'd200, 0);
		send_pixel(8'd60, 8'd200, 8'd200, 0);
		send_pixel(8'd255, 8'd255, 8'd0, 0);
		send_pixel(8'd30, 8'd10, 8'd0, 0);

		// fill the pipe against a stalled receiver
		write_vibrance(-8'sd60);
		hold_request = 1;
		repeat (40) send_colorful(0);

		// random phases across strengths, extremes included
		for (int phase = 0; phase < 16; phase++) begin
			if (phase < 8) write_vibrance(strengths[phase]);
			else write_vibrance(8'($urandom_range(0, 255)));
			stall_enable = (phase % 4 != 3);
			for (int k = 0; k < 105; k++) begin
				if ($urandom_range(0, 9) < 8) send_colorful(phase % 4 != 2);
				else send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), phase % 4 != 2);
			end
		end

		in_valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (PIPE_LATENCY * 3) @(posedge clk);
		$display("checked %0d pixels, %0d of them boosted, across 18 vibrance settings",
			board.checked, board.boosted);
		if (board.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

[pixel_vibrance_adjust_core.f]
sv/pva_pkg.sv
sv/pixel_vibrance_adjust_core.sv
dv/pixel_vibrance_adjust_core_test.sv
